@@ design/mtp_pkg.sv @@
package mtp_pkg;

  localparam int WORD_W        = 32;
  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;

  localparam logic [WORD_W-1:0] TWIST_MATRIX     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] SEED_MULT        = 32'd1812433253;
  localparam logic [WORD_W-1:0] TEMPER_B         = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C         = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] DEFAULT_SEED_RST = 32'd5489;

  localparam logic MODE_RESEED   = 1'b0;
  localparam logic MODE_GENERATE = 1'b1;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ design/mtp_in_if.sv @@
interface mtp_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [mtp_pkg::WORD_W-1:0] seed;

  modport source (output valid, output mode, output seed, input ready);
  modport sink (input valid, input mode, input seed, output ready);
endinterface

@@ design/mtp_out_if.sv @@
interface mtp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtp_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

@@ design/mtp_ram.sv @@
module mtp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/mersenne_twister_prng.sv @@
// channel   dir  beat fields              results
// in_chan   in   mode[0], seed[31:0]       mode 0: none, mode 1: one word
// out_chan  out  random_word[31:0]         one per generate beat
// cfg       in   cfg_we, cfg_data[31:0]    default seed, written at once
//
// a generate beat passes S_RD1, S_RD2 and S_TW: the single state ram read port
// fetches word p, word p+1 and word p+397 before the twisted word is written back.
// a reseed beat sweeps every state word, one state word written per cycle; a
// generate beat before any reseed adds that sweep first.
// rst_n is synchronous; the state ram is not cleared and is seeded on use.
// a result that waits on out_chan holds the next generate beat in its last
// cycle; a reseed beat still proceeds.
module mersenne_twister_prng #(
  parameter int STATE_WORDS   = mtp_pkg::STATE_WORDS,
  parameter int MIDDLE_OFFSET = mtp_pkg::MIDDLE_OFFSET
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mtp_in_if.sink                     in_chan,
  mtp_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [mtp_pkg::WORD_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(STATE_WORDS);
  localparam int WORD_W = mtp_pkg::WORD_W;
  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W:0]   MID_OFS   = (ADDR_W+1)'(MIDDLE_OFFSET);
  localparam logic [ADDR_W:0]   DEPTH_VAL = (ADDR_W+1)'(STATE_WORDS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SEED = 6'b000010,
    S_GEN0 = 6'b000100,
    S_RD1  = 6'b001000,
    S_RD2  = 6'b010000,
    S_TW   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic                seeded_r, seeded_nxt;
  logic                pend_gen_r, pend_gen_nxt;
  logic [ADDR_W-1:0]   seed_idx_r, seed_idx_nxt;
  logic [WORD_W-1:0]   seed_word_r, seed_word_nxt;
  logic                hi_bit_r, hi_bit_nxt;
  logic [WORD_W-2:0]   lo_bits_r, lo_bits_nxt;
  logic [WORD_W-1:0]   default_seed_r;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_word_r, out_word_nxt;

  logic                in_acc;
  logic                out_free;
  logic [ADDR_W-1:0]   nxt_idx;
  logic [ADDR_W:0]     mid_sum;
  logic [ADDR_W-1:0]   mid_idx;
  logic [ADDR_W-1:0]   seed_idx_inc;
  logic [WORD_W-1:0]   seed_mix;
  logic [WORD_W-1:0]   seed_prod;
  logic [WORD_W-1:0]   twisted;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  mtp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_chan.ready        = (state_r == S_IDLE);
  assign in_acc               = in_chan.valid && in_chan.ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.random_word = out_word_r;
  assign out_free             = !out_valid_r || out_chan.ready;

  assign nxt_idx = (pos_r == LAST_IDX) ? '0 : pos_r + 1'b1;
  assign mid_sum = {1'b0, pos_r} + MID_OFS;
  assign mid_idx = (mid_sum >= DEPTH_VAL) ? ADDR_W'(mid_sum - DEPTH_VAL)
                                          : mid_sum[ADDR_W-1:0];

  // seeding recurrence, one word per cycle
  assign seed_idx_inc = seed_idx_r + 1'b1;
  assign seed_mix     = seed_word_r ^ (seed_word_r >> 30);
  assign seed_prod    = mtp_pkg::SEED_MULT * seed_mix;

  // ram_rdata holds the middle word in S_TW
  assign twisted = ram_rdata ^ {1'b0, hi_bit_r, lo_bits_r[WORD_W-2:1]}
                 ^ (lo_bits_r[0] ? mtp_pkg::TWIST_MATRIX : '0);

  always_comb begin
    case (state_r)
      S_RD1:       ram_raddr = nxt_idx;
      S_RD2, S_TW: ram_raddr = mid_idx;
      default:     ram_raddr = pos_r;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    seeded_nxt    = seeded_r;
    pend_gen_nxt  = pend_gen_r;
    seed_idx_nxt  = seed_idx_r;
    seed_word_nxt = seed_word_r;
    hi_bit_nxt    = hi_bit_r;
    lo_bits_nxt   = lo_bits_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = twisted;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_chan.mode == mtp_pkg::MODE_RESEED) begin
            seed_word_nxt = in_chan.seed;
            seed_idx_nxt  = '0;
            pend_gen_nxt  = 1'b0;
            state_nxt     = S_SEED;
          end else if (!seeded_r) begin
            seed_word_nxt = default_seed_r;
            seed_idx_nxt  = '0;
            pend_gen_nxt  = 1'b1;
            state_nxt     = S_SEED;
          end else begin
            state_nxt = S_RD1;
          end
        end
      end
      S_SEED: begin
        ram_we        = 1'b1;
        ram_waddr     = seed_idx_r;
        ram_wdata     = seed_word_r;
        seed_word_nxt = seed_prod + WORD_W'(seed_idx_inc);
        seed_idx_nxt  = seed_idx_inc;
        if (seed_idx_r == LAST_IDX) begin
          pos_nxt    = '0;
          seeded_nxt = 1'b1;
          state_nxt  = pend_gen_r ? S_GEN0 : S_IDLE;
        end
      end
      S_GEN0: begin
        state_nxt = S_RD1;
      end
      S_RD1: begin
        hi_bit_nxt = ram_rdata[WORD_W-1];
        state_nxt  = S_RD2;
      end
      S_RD2: begin
        lo_bits_nxt = ram_rdata[WORD_W-2:0];
        state_nxt   = S_TW;
      end
      S_TW: begin
        if (out_free) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_word_nxt  = mtp_pkg::temper(twisted);
          pos_nxt       = nxt_idx;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pos_r          <= '0;
      seeded_r       <= 1'b0;
      pend_gen_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      default_seed_r <= mtp_pkg::DEFAULT_SEED_RST;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      seeded_r    <= seeded_nxt;
      pend_gen_r  <= pend_gen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        default_seed_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    seed_idx_r  <= seed_idx_nxt;
    seed_word_r <= seed_word_nxt;
    hi_bit_r    <= hi_bit_nxt;
    lo_bits_r   <= lo_bits_nxt;
    out_word_r  <= out_word_nxt;
  end

endmodule

@@ design/mtp_checker.sv @@
module mtp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_mode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mtp_pkg::WORD_W-1:0] out_word
);

  // a pending result stays up until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a pending result keeps its word
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  // each accepted beat leaves the input side busy in the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // a reseed beat never produces a result of its own
  a_reseed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == mtp_pkg::MODE_RESEED) && !out_valid
      |=> !out_valid)
    else $error("result appeared after a reseed beat");

  // results are loaded only while the input side is busy
  a_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result loaded while block was idle");

endmodule

bind mersenne_twister_prng mtp_checker u_mtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_mode   (in_chan.mode),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_word  (out_chan.random_word)
);

@@ test/mersenne_twister_prng_tb.sv @@
`timescale 1ns / 1ps

module mersenne_twister_prng_tb;

  localparam int WORD_W       = mtp_pkg::WORD_W;
  localparam int STATE_WORDS  = mtp_pkg::STATE_WORDS;
  localparam int SWEEP_CYCLES = 700;  // long enough to cover a reseed sweep

  class mt_scoreboard;
    logic [WORD_W-1:0] mt_words[STATE_WORDS];
    int unsigned       word_pos;
    bit                is_seeded;
    logic [WORD_W-1:0] dflt_seed;
    logic [WORD_W-1:0] expected_words[$];
    int                errors;
    int                words_checked;
    int                reseeds;
    int                twists;

    function new();
      word_pos      = STATE_WORDS;
      is_seeded     = 1'b0;
      dflt_seed     = mtp_pkg::DEFAULT_SEED_RST;
      errors        = 0;
      words_checked = 0;
      reseeds       = 0;
      twists        = 0;
    endfunction

    function void set_default_seed(input logic [WORD_W-1:0] v);
      dflt_seed = v;
    endfunction

    function void load_state(input logic [WORD_W-1:0] s);
      logic [WORD_W-1:0] prev;
      mt_words[0] = s;
      for (int i = 1; i < STATE_WORDS; i++) begin
        prev        = mt_words[i-1];
        mt_words[i] = mtp_pkg::SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(i);
      end
      word_pos  = STATE_WORDS;
      is_seeded = 1'b1;
    endfunction

    function void note_input(input logic mode, input logic [WORD_W-1:0] seed);
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] v;
      if (mode == mtp_pkg::MODE_RESEED) begin
        load_state(seed);
        reseeds++;
        return;
      end
      if (!is_seeded) load_state(dflt_seed);
      if (word_pos >= STATE_WORDS) begin
        for (int k = 0; k < STATE_WORDS; k++) begin
          y = (mt_words[k] & 32'h8000_0000) |
              (mt_words[(k + 1) % STATE_WORDS] & 32'h7fff_ffff);
          v = mt_words[(k + mtp_pkg::MIDDLE_OFFSET) % STATE_WORDS] ^ (y >> 1);
          if (y[0]) v = v ^ mtp_pkg::TWIST_MATRIX;
          mt_words[k] = v;
        end
        word_pos = 0;
        twists++;
      end
      // tempering
      y = mt_words[word_pos];
      word_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & mtp_pkg::TEMPER_B);
      y = y ^ ((y << 15) & mtp_pkg::TEMPER_C);
      y = y ^ (y >> 18);
      expected_words.push_back(y);
    endfunction

    function void check_word(input logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected random_word beat, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (got !== want) begin
        $display("%0t: random_word mismatch, expected %h, actual %h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_data;
  int                items_sent;
  int                cfg_writes;

  mtp_in_if  in_if ();
  mtp_out_if out_if ();

  mt_scoreboard model;

  mersenne_twister_prng uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, one long hold-off, then a calm stretch
  initial begin : result_sink
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && model.words_checked >= 200) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (model.words_checked >= 400 && model.words_checked < 900) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 7);
      end
      @(posedge clk);
      if (out_if.valid && out_if.ready) model.check_word(out_if.random_word);
    end
  end

  task automatic send_beat(input logic mode, input logic [WORD_W-1:0] seed);
    @(negedge clk);
    while (!(items_sent >= 400 && items_sent < 900) && $urandom_range(99) < 7) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= mode;
    in_if.seed  <= seed;
    do @(posedge clk); while (!in_if.ready);
    model.note_input(mode, seed);
    items_sent++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (model.expected_words.size() != 0) @(posedge clk);
    // a trailing reseed gives no beat but may still be sweeping
    repeat (SWEEP_CYCLES) @(posedge clk);
  endtask

  task automatic write_default_seed(input logic [WORD_W-1:0] v);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    model.set_default_seed(v);
    cfg_writes++;
  endtask

  // each run: reseed, then a burst of generate beats
  task automatic run_bursts(input int budget, input bit long_first);
    int               sent;
    int               burst;
    int               pick;
    logic [WORD_W-1:0] s;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) == 0) s = $urandom_range(1) ? '1 : '0;
      else s = $urandom;
      send_beat(mtp_pkg::MODE_RESEED, s);
      pick = $urandom_range(99);
      if (long_first && sent == 0) burst = 1300;
      else if (pick < 8) burst = 0;
      else if (pick < 30) burst = $urandom_range(700, 620);
      else burst = $urandom_range(40, 1);
      // keep the run within its budget
      if (burst > budget - sent - 1) burst = budget - sent - 1;
      sent += 1 + burst;
      repeat (burst) send_beat(mtp_pkg::MODE_GENERATE, $urandom);
    end
  endtask

  initial begin
    model        = new();
    items_sent   = 0;
    cfg_writes   = 0;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.mode   = mtp_pkg::MODE_RESEED;
    in_if.seed   = '0;
    out_if.ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // first words come from the reset default seed
    repeat (3) send_beat(mtp_pkg::MODE_GENERATE, $urandom);
    send_beat(mtp_pkg::MODE_RESEED, 32'h0000_0000);
    repeat (2) send_beat(mtp_pkg::MODE_GENERATE, 32'h0000_0000);
    send_beat(mtp_pkg::MODE_RESEED, 32'hffff_ffff);
    send_beat(mtp_pkg::MODE_GENERATE, 32'hffff_ffff);
    // back-to-back reseeds, only the second one counts
    send_beat(mtp_pkg::MODE_RESEED, 32'h8000_0000);
    send_beat(mtp_pkg::MODE_RESEED, 32'h7fff_ffff);
    repeat (2) send_beat(mtp_pkg::MODE_GENERATE, 32'h5555_5555);
    send_beat(mtp_pkg::MODE_RESEED, 32'h0000_0001);
    send_beat(mtp_pkg::MODE_GENERATE, 32'hffff_ffff);
    send_beat(mtp_pkg::MODE_GENERATE, 32'h0000_0000);
    send_beat(mtp_pkg::MODE_RESEED, mtp_pkg::DEFAULT_SEED_RST);
    send_beat(mtp_pkg::MODE_GENERATE, 32'haaaa_aaaa);
    drain_and_settle();

    write_default_seed(32'h0000_0000);
    run_bursts(1400, 1'b1);
    drain_and_settle();
    write_default_seed(32'hffff_ffff);
    run_bursts(300, 1'b0);
    drain_and_settle();
    write_default_seed($urandom);
    run_bursts(300, 1'b0);
    drain_and_settle();

    if (model.expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, model.expected_words.size());
    end
    $display("%0d beats sent: %0d reseeds, %0d words checked across %0d full twists",
             items_sent, model.reseeds, model.words_checked, model.twists);
    $display("default seed register written %0d times, receiver held off once", cfg_writes);
    if (model.errors == 0 && model.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
